// ===== design/planar_three_link_inverse_kinematics_assert.svh =====
// Assertion macros for the planar three-link IK block.
// Included by the RTL files that assert; needs nothing else.
`ifndef PLANAR_THREE_LINK_INVERSE_KINEMATICS_ASSERT_SVH
`define PLANAR_THREE_LINK_INVERSE_KINEMATICS_ASSERT_SVH
`ifndef SYNTH
`define P3IK_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("p3ik assertion failed");
`define P3IK_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("p3ik reset assertion failed");
`else
`define P3IK_ASSERT(label, clk, rst, prop)
`define P3IK_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== design/p3ik_pkg.sv =====
// Shared widths, constants, arctangent table and sideband types for the
// planar three-link IK pipeline. No dependencies.
`default_nettype none
package p3ik_pkg;
  localparam int FRAC   = 16;
  localparam int STEPS  = 20;
  localparam int GUARD  = 8;
  localparam int LEN_W  = 20;
  localparam int POS_W  = 24;
  localparam int TH_W   = 19;
  localparam int ANG_W  = 24;
  localparam int Z_W    = 21;
  localparam int RC_W   = 20;
  localparam int WX_W   = 26;
  localparam int SQ_W   = 52;
  localparam int NUM_W  = 53;
  localparam int DEN_W  = 41;
  localparam int R_W    = 42;
  localparam int D_W    = FRAC + 2;
  localparam int S_W    = FRAC + 1;
  localparam int ADDR_W = 4;

  localparam logic signed [Z_W-1:0]  PI_Q      = 21'sd205887;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q = 21'sd102944;
  localparam logic signed [Z_W-1:0]  TWO_PI_Q  = 21'sd411774;
  localparam logic signed [RC_W-1:0] GAIN_Q    = 20'sd39797;
  localparam logic signed [D_W-1:0]  ONE_Q     = 18'sd65536;

  localparam logic [1:0] REG_LINK1 = 2'd0;
  localparam logic [1:0] REG_LINK2 = 2'd1;
  localparam logic [1:0] REG_LINK3 = 2'd2;

  localparam logic [LEN_W-1:0] LINK1_RST = 20'd28180;
  localparam logic [LEN_W-1:0] LINK2_RST = 20'd21627;
  localparam logic [LEN_W-1:0] LINK3_RST = 20'd15729;

  // atan(2^-i) with 30 fraction bits, rounded to FRAC bits
  function automatic logic signed [Z_W-1:0] atan_tbl(input int i);
    logic [31:0] q;
    logic [31:0] r;
    unique case (i)
      0:  q = 32'd843314857;
      1:  q = 32'd497837829;
      2:  q = 32'd263043837;
      3:  q = 32'd133525159;
      4:  q = 32'd67021687;
      5:  q = 32'd33543516;
      6:  q = 32'd16775851;
      7:  q = 32'd8388437;
      8:  q = 32'd4194283;
      9:  q = 32'd2097149;
      10: q = 32'd1048576;
      11: q = 32'd524288;
      12: q = 32'd262144;
      13: q = 32'd131072;
      14: q = 32'd65536;
      15: q = 32'd32768;
      16: q = 32'd16384;
      17: q = 32'd8192;
      18: q = 32'd4096;
      19: q = 32'd2048;
      20: q = 32'd1024;
      21: q = 32'd512;
      22: q = 32'd256;
      23: q = 32'd128;
      24: q = 32'd64;
      25: q = 32'd32;
      26: q = 32'd16;
      27: q = 32'd8;
      default: q = 32'd0;
    endcase
    r = (q + (32'd1 << (30 - FRAC - 1))) >> (30 - FRAC);
    atan_tbl = $signed(r[Z_W-1:0]);
  endfunction

  typedef struct packed {
    logic signed [POS_W-1:0] tx;
    logic signed [POS_W-1:0] ty;
    logic signed [TH_W-1:0]  th;
  } pose_tag_t;

  typedef struct packed {
    logic signed [WX_W-1:0] wx;
    logic signed [WX_W-1:0] wy;
    logic signed [TH_W-1:0] th;
    logic                   solv;
  } wrist_tag_t;

  typedef struct packed {
    wrist_tag_t            w;
    logic signed [D_W-1:0] d;
  } sqrt_tag_t;

  typedef struct packed {
    logic signed [TH_W-1:0] th;
    logic                   solv;
  } angle_tag_t;
endpackage
`default_nettype wire

// ===== design/p3ik_pose_if.sv =====
// Input channel carrying one target pose per beat.
// Depends on p3ik_pkg.
`default_nettype none
interface p3ik_pose_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [p3ik_pkg::POS_W-1:0]    target_x;
  logic signed [p3ik_pkg::POS_W-1:0]    target_y;
  logic signed [p3ik_pkg::TH_W-1:0]     target_angle;
  modport source (output valid, target_x, target_y, target_angle, input ready);
  modport sink   (input valid, target_x, target_y, target_angle, output ready);
endinterface
`default_nettype wire

// ===== design/p3ik_joint_if.sv =====
// Output channel carrying one joint solution per beat.
// Depends on p3ik_pkg.
`default_nettype none
interface p3ik_joint_if;
  logic                              valid;
  logic                              ready;
  logic                              solvable;
  logic signed [p3ik_pkg::ANG_W-1:0] base_angle;
  logic signed [p3ik_pkg::ANG_W-1:0] elbow_angle;
  logic signed [p3ik_pkg::ANG_W-1:0] wrist_angle;
  modport source (output valid, solvable, base_angle, elbow_angle, wrist_angle,
                  input ready);
  modport sink   (input valid, solvable, base_angle, elbow_angle, wrist_angle,
                  output ready);
endinterface
`default_nettype wire

// ===== design/planar_three_link_inverse_kinematics.sv =====
// Top level of the planar three-link IK pipeline: APB link registers,
// wrist and law-of-cosines stages. Uses p3ik_pkg, the channel interfaces,
// p3ik_rot_cordic, p3ik_div, p3ik_sqrt, p3ik_vec_cordic and the assert macros.
//
// Channel  Side   Beat contents
// pose     in     target_x, target_y, target_angle
// joints   out    solvable, base_angle, elbow_angle, wrist_angle
// apb      cfg    link1/2/3_length at byte 0x0 / 0x4 / 0x8, 20 bits each
//
// One pose is accepted every cycle while joints is not stalled; each result
// passes through the two 20-step CORDICs, the 18-stage divider and the
// 19-stage square root, all one step per register stage.
// Reset (rst, synchronous) clears all stage valid bits and loads the link
// registers; data registers are not reset.
// A stall on joints freezes the whole pipe, pose.ready drops with it.
`default_nettype none
`include "planar_three_link_inverse_kinematics_assert.svh"
module planar_three_link_inverse_kinematics (
  input  logic                          clk,
  input  logic                          rst,
  p3ik_pose_if.sink                     pose,
  p3ik_joint_if.source                  joints,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [p3ik_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import p3ik_pkg::*;

  // ---------------- link registers ----------------
  logic [LEN_W-1:0] link1;
  logic [LEN_W-1:0] link2;
  logic [LEN_W-1:0] link3;
  logic [1:0]       reg_idx;
  logic             wr;

  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      link1 <= LINK1_RST;
      link2 <= LINK2_RST;
      link3 <= LINK3_RST;
    end else if (wr) begin
      unique case (reg_idx)
        REG_LINK1: link1 <= pwdata[LEN_W-1:0];
        REG_LINK2: link2 <= pwdata[LEN_W-1:0];
        REG_LINK3: link3 <= pwdata[LEN_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LINK1: prdata = 32'(link1);
      REG_LINK2: prdata = 32'(link2);
      REG_LINK3: prdata = 32'(link3);
      default:   prdata = '0;
    endcase
  end

  // link-derived terms; registers settle long before an item reaches them
  logic [DEN_W-1:0]       den;
  logic [2*LEN_W-1:0]     l1sq;
  logic [2*LEN_W-1:0]     l2sq;
  logic signed [LEN_W:0]  l1s;
  logic signed [LEN_W:0]  l2s;
  logic signed [LEN_W:0]  l3s;

  assign l1s = $signed({1'b0, link1});
  assign l2s = $signed({1'b0, link2});
  assign l3s = $signed({1'b0, link3});

  always_ff @(posedge clk) begin
    den  <= {(2*LEN_W)'(link1) * (2*LEN_W)'(link2), 1'b0};
    l1sq <= link1 * link1;
    l2sq <= link2 * link2;
  end

  // global advance: the whole pipe moves unless the output beat is stuck
  logic en;
  logic o_vld;
  assign en         = !o_vld || joints.ready;
  assign pose.ready = en;

  // ---------------- sin / cos of theta ----------------
  pose_tag_t             rot_tag_in;
  logic [$bits(pose_tag_t)-1:0] rot_tag_bits;
  pose_tag_t             rot_tag;
  logic                  rot_vld;
  logic signed [RC_W-1:0] rot_cos;
  logic signed [RC_W-1:0] rot_sin;

  assign rot_tag_in = '{tx: pose.target_x, ty: pose.target_y, th: pose.target_angle};

  p3ik_rot_cordic #(.TAG_W($bits(pose_tag_t))) u_rot (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (pose.valid),
    .t_in    (pose.target_angle),
    .tag_in  (rot_tag_in),
    .out_vld (rot_vld),
    .cos_out (rot_cos),
    .sin_out (rot_sin),
    .tag_out (rot_tag_bits)
  );
  assign rot_tag = rot_tag_bits;

  // ---------------- wrist point and law of cosines ----------------
  localparam logic signed [2*LEN_W:0] HALF_LSB = (2*LEN_W+1)'(1) << (FRAC - 1);

  logic                     m1_vld, m2_vld, m3_vld, m4_vld, m5_vld;
  logic signed [2*LEN_W:0]  m1_pc, m1_ps;
  pose_tag_t                m1_tag;
  logic signed [WX_W-1:0]   m2_wx, m2_wy;
  logic signed [TH_W-1:0]   m2_th;
  logic signed [SQ_W-1:0]   m3_sqx, m3_sqy;
  logic signed [WX_W-1:0]   m3_wx, m3_wy;
  logic signed [TH_W-1:0]   m3_th;
  logic signed [NUM_W-1:0]  m4_num;
  logic                     m4_lok;
  logic signed [WX_W-1:0]   m4_wx, m4_wy;
  logic signed [TH_W-1:0]   m4_th;
  logic [NUM_W-1:0]         m5_abs;
  logic                     m5_neg;
  wrist_tag_t               m5_tag;

  logic signed [2*LEN_W:0]  rc_x, rc_y;
  logic [NUM_W-1:0]         abs_num;

  assign rc_x    = (m1_pc + HALF_LSB) >>> FRAC;
  assign rc_y    = (m1_ps + HALF_LSB) >>> FRAC;
  assign abs_num = m4_num[NUM_W-1] ? $unsigned(-m4_num) : $unsigned(m4_num);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      m3_vld <= 1'b0;
      m4_vld <= 1'b0;
      m5_vld <= 1'b0;
    end else if (en) begin
      m1_vld <= rot_vld;
      m2_vld <= m1_vld;
      m3_vld <= m2_vld;
      m4_vld <= m3_vld;
      m5_vld <= m4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // l3 * (cos, sin)
      m1_pc  <= l3s * rot_cos;
      m1_ps  <= l3s * rot_sin;
      m1_tag <= rot_tag;
      // wrist point
      m2_wx  <= WX_W'(m1_tag.tx) - WX_W'(rc_x);
      m2_wy  <= WX_W'(m1_tag.ty) - WX_W'(rc_y);
      m2_th  <= m1_tag.th;
      // squares
      m3_sqx <= m2_wx * m2_wx;
      m3_sqy <= m2_wy * m2_wy;
      m3_wx  <= m2_wx;
      m3_wy  <= m2_wy;
      m3_th  <= m2_th;
      // N = wx^2 + wy^2 - l1^2 - l2^2
      m4_num <= NUM_W'(m3_sqx) + NUM_W'(m3_sqy) - NUM_W'(l1sq) - NUM_W'(l2sq);
      m4_lok <= (link1 != '0) && (link2 != '0);
      m4_wx  <= m3_wx;
      m4_wy  <= m3_wy;
      m4_th  <= m3_th;
      // exact reach test |N| <= 2*l1*l2
      m5_abs      <= abs_num;
      m5_neg      <= m4_num[NUM_W-1];
      m5_tag.wx   <= m4_wx;
      m5_tag.wy   <= m4_wy;
      m5_tag.th   <= m4_th;
      m5_tag.solv <= m4_lok && (abs_num <= NUM_W'(den));
    end
  end

  // ---------------- D = N / (2 l1 l2) ----------------
  logic                         div_vld;
  logic signed [D_W-1:0]        div_d;
  logic [$bits(wrist_tag_t)-1:0] div_tag_bits;
  wrist_tag_t                   div_tag;

  p3ik_div #(.TAG_W($bits(wrist_tag_t))) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (m5_vld),
    .num_abs (m5_abs[R_W-1:0]),
    .num_neg (m5_neg),
    .den     (den),
    .tag_in  (m5_tag),
    .out_vld (div_vld),
    .d_out   (div_d),
    .tag_out (div_tag_bits)
  );
  assign div_tag = div_tag_bits;

  // ---------------- sqrt(1 - D^2) ----------------
  sqrt_tag_t                    sq_tag_in;
  logic                         sq_vld;
  logic [S_W-1:0]               sq_s;
  logic [$bits(sqrt_tag_t)-1:0] sq_tag_bits;
  sqrt_tag_t                    sq_tag;

  assign sq_tag_in = '{w: div_tag, d: div_d};

  p3ik_sqrt #(.TAG_W($bits(sqrt_tag_t))) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (div_vld),
    .d_in    (div_d),
    .tag_in  (sq_tag_in),
    .out_vld (sq_vld),
    .s_out   (sq_s),
    .tag_out (sq_tag_bits)
  );
  assign sq_tag = sq_tag_bits;

  // ---------------- k1 = l1 + l2*D, k2 = l2*S ----------------
  localparam int KP_W = LEN_W + 1 + D_W;
  localparam logic signed [KP_W-1:0] KHALF = KP_W'(1) << (FRAC - 1);

  logic                   k1_vld, k2_vld;
  logic signed [KP_W-1:0] k1_pd, k1_ps;
  logic [S_W-1:0]         k1_s;
  sqrt_tag_t              k1_tag;
  logic signed [WX_W-1:0] k2_k1, k2_k2;
  logic [S_W-1:0]         k2_s;
  sqrt_tag_t              k2_tag;
  logic signed [KP_W-1:0] kr_d, kr_s;

  assign kr_d = (k1_pd + KHALF) >>> FRAC;
  assign kr_s = (k1_ps + KHALF) >>> FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      k1_vld <= 1'b0;
      k2_vld <= 1'b0;
    end else if (en) begin
      k1_vld <= sq_vld;
      k2_vld <= k1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1_pd  <= l2s * sq_tag.d;
      k1_ps  <= l2s * $signed({1'b0, sq_s});
      k1_s   <= sq_s;
      k1_tag <= sq_tag;
      k2_k1  <= WX_W'(l1s) + WX_W'(kr_d);
      k2_k2  <= WX_W'(kr_s);
      k2_s   <= k1_s;
      k2_tag <= k1_tag;
    end
  end

  // ---------------- three atan2 lanes ----------------
  // lane 0: q2 = atan2(S, D); lane 1: atan2(wy, wx); lane 2: atan2(k2, k1)
  logic signed [WX_W-1:0]  vy [3];
  logic signed [WX_W-1:0]  vx [3];
  logic signed [Z_W-1:0]   vz [3];
  angle_tag_t              v_tag_in;
  logic [$bits(angle_tag_t)-1:0] v_tag_bits;
  angle_tag_t              v_tag;
  logic                    v_vld;

  assign vy[0] = $signed(WX_W'(k2_s));
  assign vx[0] = WX_W'(k2_tag.d);
  assign vy[1] = k2_tag.w.wy;
  assign vx[1] = k2_tag.w.wx;
  assign vy[2] = k2_k2;
  assign vx[2] = k2_k1;
  assign v_tag_in = '{th: k2_tag.w.th, solv: k2_tag.w.solv};

  p3ik_vec_cordic #(.LANES(3), .IN_W(WX_W), .TAG_W($bits(angle_tag_t))) u_vec (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (k2_vld),
    .y_in    (vy),
    .x_in    (vx),
    .tag_in  (v_tag_in),
    .out_vld (v_vld),
    .z_out   (vz),
    .tag_out (v_tag_bits)
  );
  assign v_tag = v_tag_bits;

  // ---------------- joint angles, output register ----------------
  logic signed [ANG_W-1:0] q1, q2, q3;
  logic                    o_solv;
  logic signed [ANG_W-1:0] o_q1, o_q2, o_q3;

  assign q1 = ANG_W'(vz[1]) - ANG_W'(vz[2]);
  assign q2 = ANG_W'(vz[0]);
  assign q3 = ANG_W'(v_tag.th) - q1 - q2;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= v_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_solv <= v_tag.solv;
      o_q1   <= v_tag.solv ? q1 : '0;
      o_q2   <= v_tag.solv ? q2 : '0;
      o_q3   <= v_tag.solv ? q3 : '0;
    end
  end

  assign joints.valid       = o_vld;
  assign joints.solvable    = o_solv;
  assign joints.base_angle  = o_q1;
  assign joints.elbow_angle = o_q2;
  assign joints.wrist_angle = o_q3;

  // ---------------- checks ----------------
  `P3IK_ASSERT(a_unsolv_zero, clk, rst, o_vld && !o_solv |-> (o_q1 == '0) && (o_q2 == '0) && (o_q3 == '0))
  `P3IK_ASSERT_NORST(a_rst_clear, clk, rst |=> !o_vld && !m1_vld && !k1_vld)
  `P3IK_ASSERT(a_d_range, clk, rst, div_vld && div_tag.solv |-> (div_d <= ONE_Q) && (div_d >= -ONE_Q))
  `P3IK_ASSERT(a_s_range, clk, rst, sq_vld && sq_tag.w.solv |-> (sq_s <= S_W'(ONE_Q)))
endmodule
`default_nettype wire

// ===== design/p3ik_rot_cordic.sv =====
// Pipelined rotation CORDIC: cos and sin of the end orientation.
// One register stage for range reduction, one per iteration. Uses p3ik_pkg.
`default_nettype none
module p3ik_rot_cordic #(
  parameter int TAG_W = 67
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic signed [p3ik_pkg::TH_W-1:0] t_in,
  input  logic [TAG_W-1:0]                 tag_in,
  output logic                             out_vld,
  output logic signed [p3ik_pkg::RC_W-1:0] cos_out,
  output logic signed [p3ik_pkg::RC_W-1:0] sin_out,
  output logic [TAG_W-1:0]                 tag_out
);
  import p3ik_pkg::*;

  logic                   vld [STEPS+1];
  logic signed [RC_W-1:0] xs  [STEPS+1];
  logic signed [RC_W-1:0] ys  [STEPS+1];
  logic signed [Z_W-1:0]  zs  [STEPS+1];
  logic                   ng  [STEPS+1];
  logic [TAG_W-1:0]       tg  [STEPS+1];

  logic signed [Z_W-1:0] t_ext;
  logic signed [Z_W-1:0] t_red;
  logic signed [Z_W-1:0] t_fold;
  logic                  fold;

  // wrap into [-pi, pi), then fold into [-pi/2, pi/2]
  always_comb begin
    t_ext = Z_W'(t_in);
    if (t_ext >= PI_Q) begin
      t_red = t_ext - TWO_PI_Q;
    end else if (t_ext < -PI_Q) begin
      t_red = t_ext + TWO_PI_Q;
    end else begin
      t_red = t_ext;
    end
    fold   = 1'b0;
    t_fold = t_red;
    if (t_red > HALF_PI_Q) begin
      t_fold = t_red - PI_Q;
      fold   = 1'b1;
    end else if (t_red < -HALF_PI_Q) begin
      t_fold = t_red + PI_Q;
      fold   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= GAIN_Q;
      ys[0] <= '0;
      zs[0] <= t_fold;
      ng[0] <= fold;
      tg[0] <= tag_in;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_iter
    logic signed [RC_W-1:0] dx;
    logic signed [RC_W-1:0] dy;
    logic signed [RC_W-1:0] xn;
    logic signed [RC_W-1:0] yn;
    logic signed [Z_W-1:0]  zn;

    always_comb begin
      dx = ys[k] >>> k;
      dy = xs[k] >>> k;
      if (zs[k] >= 0) begin
        xn = xs[k] - dx;
        yn = ys[k] + dy;
        zn = zs[k] - atan_tbl(k);
      end else begin
        xn = xs[k] + dx;
        yn = ys[k] - dy;
        zn = zs[k] + atan_tbl(k);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k+1] <= xn;
        ys[k+1] <= yn;
        zs[k+1] <= zn;
        ng[k+1] <= ng[k];
        tg[k+1] <= tg[k];
      end
    end
  end

  assign out_vld = vld[STEPS];
  assign cos_out = ng[STEPS] ? -xs[STEPS] : xs[STEPS];
  assign sin_out = ng[STEPS] ? -ys[STEPS] : ys[STEPS];
  assign tag_out = tg[STEPS];
endmodule
`default_nettype wire

// ===== design/p3ik_vec_cordic.sv =====
// Pipelined vectoring CORDIC, several atan2 lanes sharing one valid/tag.
// Pre-rotation by pi for x < 0; atan2(0, 0) gives 0. Uses p3ik_pkg.
`default_nettype none
module p3ik_vec_cordic #(
  parameter int LANES = 3,
  parameter int IN_W  = 26,
  parameter int TAG_W = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic signed [IN_W-1:0]          y_in [LANES],
  input  logic signed [IN_W-1:0]          x_in [LANES],
  input  logic [TAG_W-1:0]                tag_in,
  output logic                            out_vld,
  output logic signed [p3ik_pkg::Z_W-1:0] z_out [LANES],
  output logic [TAG_W-1:0]                tag_out
);
  import p3ik_pkg::*;

  localparam int W = IN_W + GUARD + 2;

  logic                  vld [STEPS+1];
  logic [TAG_W-1:0]      tg  [STEPS+1];
  logic signed [W-1:0]   xs  [STEPS+1][LANES];
  logic signed [W-1:0]   ys  [STEPS+1][LANES];
  logic signed [Z_W-1:0] zs  [STEPS+1][LANES];
  logic                  zr  [STEPS+1][LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tg[0] <= tag_in;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_pre
    logic signed [W-1:0]   xe;
    logic signed [W-1:0]   ye;
    logic signed [W-1:0]   xp;
    logic signed [W-1:0]   yp;
    logic signed [Z_W-1:0] zp;

    always_comb begin
      xe = W'(x_in[l]) <<< GUARD;
      ye = W'(y_in[l]) <<< GUARD;
      xp = xe;
      yp = ye;
      zp = '0;
      if (xe < 0) begin
        zp = (ye >= 0) ? PI_Q : -PI_Q;
        xp = -xe;
        yp = -ye;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[0][l] <= xp;
        ys[0][l] <= yp;
        zs[0][l] <= zp;
        zr[0][l] <= (x_in[l] == '0) && (y_in[l] == '0);
      end
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tg[k+1] <= tg[k];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [W-1:0]   dx;
      logic signed [W-1:0]   dy;
      logic signed [W-1:0]   xn;
      logic signed [W-1:0]   yn;
      logic signed [Z_W-1:0] zn;

      always_comb begin
        dx = ys[k][l] >>> k;
        dy = xs[k][l] >>> k;
        if (ys[k][l] >= 0) begin
          xn = xs[k][l] + dx;
          yn = ys[k][l] - dy;
          zn = zs[k][l] + atan_tbl(k);
        end else begin
          xn = xs[k][l] - dx;
          yn = ys[k][l] + dy;
          zn = zs[k][l] - atan_tbl(k);
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          xs[k+1][l] <= xn;
          ys[k+1][l] <= yn;
          zs[k+1][l] <= zn;
          zr[k+1][l] <= zr[k][l];
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign z_out[l] = zr[STEPS][l] ? '0 : zs[STEPS][l];
  end

  assign out_vld = vld[STEPS];
  assign tag_out = tg[STEPS];
endmodule
`default_nettype wire

// ===== design/p3ik_div.sv =====
// Pipelined restoring divider for D = |N| / den, one quotient bit a stage,
// rounded to nearest (ties away) and signed at the end. Uses p3ik_pkg.
`default_nettype none
module p3ik_div #(
  parameter int TAG_W = 72
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic [p3ik_pkg::R_W-1:0]         num_abs,
  input  logic                             num_neg,
  input  logic [p3ik_pkg::DEN_W-1:0]       den,
  input  logic [TAG_W-1:0]                 tag_in,
  output logic                             out_vld,
  output logic signed [p3ik_pkg::D_W-1:0]  d_out,
  output logic [TAG_W-1:0]                 tag_out
);
  import p3ik_pkg::*;

  localparam int Q_W = FRAC + 1;

  logic [R_W-1:0]   den_x;
  logic             vld [FRAC+1];
  logic [R_W-1:0]   rs  [FRAC+1];
  logic [Q_W-1:0]   qs  [FRAC+1];
  logic             ng  [FRAC+1];
  logic [TAG_W-1:0] tg  [FRAC+1];

  logic             ge0;
  logic [R_W-1:0]   rf;
  logic [Q_W-1:0]   qf;
  logic             f_vld;
  logic [D_W-1:0]   f_d;
  logic [TAG_W-1:0] f_tg;

  assign den_x = R_W'(den);
  assign ge0   = num_abs >= den_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs[0] <= ge0 ? num_abs - den_x : num_abs;
      qs[0] <= Q_W'(ge0);
      ng[0] <= num_neg;
      tg[0] <= tag_in;
    end
  end

  for (genvar j = 1; j <= FRAC; j++) begin : g_step
    logic [R_W-1:0] sh;
    logic           ge;

    assign sh = {rs[j-1][R_W-2:0], 1'b0};
    assign ge = sh >= den_x;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rs[j] <= ge ? sh - den_x : sh;
        qs[j] <= {qs[j-1][Q_W-2:0], ge};
        ng[j] <= ng[j-1];
        tg[j] <= tg[j-1];
      end
    end
  end

  // round bit from one more remainder step
  assign rf = {rs[FRAC][R_W-2:0], 1'b0};
  assign qf = qs[FRAC] + Q_W'(rf >= den_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= vld[FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_d  <= ng[FRAC] ? -D_W'(qf) : D_W'(qf);
      f_tg <= tg[FRAC];
    end
  end

  assign out_vld = f_vld;
  assign d_out   = $signed(f_d);
  assign tag_out = f_tg;
endmodule
`default_nettype wire

// ===== design/p3ik_sqrt.sv =====
// Pipelined integer square root of 2^(2F) - D^2, one result bit a stage,
// rounded to nearest. Uses p3ik_pkg.
`default_nettype none
module p3ik_sqrt #(
  parameter int TAG_W = 90
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic signed [p3ik_pkg::D_W-1:0] d_in,
  input  logic [TAG_W-1:0]                tag_in,
  output logic                            out_vld,
  output logic [p3ik_pkg::S_W-1:0]        s_out,
  output logic [TAG_W-1:0]                tag_out
);
  import p3ik_pkg::*;

  localparam int V_W = 2 * D_W;
  localparam logic [V_W-1:0] ONE_SQ = V_W'(1) << (2 * FRAC);

  logic             vld [FRAC+2];
  logic [V_W-1:0]   vs  [FRAC+2];
  logic [V_W-1:0]   rs  [FRAC+2];
  logic [TAG_W-1:0] tg  [FRAC+2];

  logic signed [V_W-1:0] dsq;
  logic             f_vld;
  logic [S_W-1:0]   f_s;
  logic [TAG_W-1:0] f_tg;

  assign dsq = d_in * d_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vs[0] <= ONE_SQ - $unsigned(dsq);
      rs[0] <= '0;
      tg[0] <= tag_in;
    end
  end

  for (genvar j = 0; j <= FRAC; j++) begin : g_step
    localparam logic [V_W-1:0] B = V_W'(1) << (2 * (FRAC - j));
    logic [V_W-1:0] rb;
    logic           ge;

    assign rb = rs[j] + B;
    assign ge = vs[j] >= rb;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vs[j+1] <= ge ? vs[j] - rb : vs[j];
        rs[j+1] <= ge ? (rs[j] >> 1) + B : rs[j] >> 1;
        tg[j+1] <= tg[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= vld[FRAC+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_s  <= S_W'(rs[FRAC+1]) + S_W'(vs[FRAC+1] > rs[FRAC+1]);
      f_tg <= tg[FRAC+1];
    end
  end

  assign out_vld = f_vld;
  assign s_out   = f_s;
  assign tag_out = f_tg;
endmodule
`default_nettype wire

// ===== tb/p3ik_tb_pkg.sv =====
// Shared test-side types and the register address map for the IK testbench.
// Depends on p3ik_pkg from the design.
`timescale 1ns / 1ps
package p3ik_tb_pkg;
  import p3ik_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0] tx;
    logic signed [POS_W-1:0] ty;
    logic signed [TH_W-1:0]  th;
  } pose_beat_t;

  typedef struct packed {
    logic                    solvable;
    logic signed [ANG_W-1:0] base;
    logic signed [ANG_W-1:0] elbow;
    logic signed [ANG_W-1:0] wrist;
  } joint_beat_t;

  localparam logic [ADDR_W-1:0] ADDR_LINK1 = ADDR_W'(4 * REG_LINK1);
  localparam logic [ADDR_W-1:0] ADDR_LINK2 = ADDR_W'(4 * REG_LINK2);
  localparam logic [ADDR_W-1:0] ADDR_LINK3 = ADDR_W'(4 * REG_LINK3);
endpackage

// ===== tb/tb_planar_three_link_inverse_kinematics.sv =====
// Self-checking bench for the planar three-link IK pipeline: fixed-point
// predictor, random pose traffic with bursty stalls, APB link updates.
// Depends on p3ik_pkg, p3ik_tb_pkg, the channel interfaces and the RTL.
`timescale 1ns / 1ps
module tb_planar_three_link_inverse_kinematics;
  import p3ik_pkg::*;
  import p3ik_tb_pkg::*;

  localparam int PIPE_LAT = 87;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  p3ik_pose_if  pose_ch ();
  p3ik_joint_if joint_ch ();

  planar_three_link_inverse_kinematics dut (
    .clk(clk), .rst(rst), .pose(pose_ch.sink), .joints(joint_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // link lengths as the predictor sees them
  longint link1, link2, link3;

  pose_beat_t  pose_queue[$];
  joint_beat_t joint_expect[$];
  int  fail_count = 0;
  bit  quiet_phase = 0;      // no stalls in the closing stretch
  int  src_gap = 0, snk_gap = 0;
  bit  pose_taken = 0;       // pose beat accepted at the last rising edge

  // ---------------- fixed-point predictor ----------------
  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd(longint v, int s);
    if (s == 0) return v;
    return sra(v + (longint'(1) << (s - 1)), s);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd(a * b, FRAC);
  endfunction

  function automatic longint atan_step(int i);
    longint q30[28] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
      32, 16, 8};
    return rnd(q30[i], 30 - FRAC);
  endfunction

  localparam longint PI30 = 64'd3373259426;
  localparam longint GAIN30 = 64'd652032874;

  // rotation CORDIC: cos and sin of t
  function automatic void rotate(input longint t, output longint c, output longint s);
    longint pi_q, half_q, two_q, x, y, z, n, k, dx, dy;
    bit flip;
    pi_q = rnd(PI30, 30 - FRAC);
    half_q = rnd(PI30, 31 - FRAC);
    two_q = 2 * pi_q;
    flip = 0;
    if (t >= pi_q || t < -pi_q) begin
      n = t + pi_q;
      if (n >= 0) k = n / two_q;
      else k = -((-n + two_q - 1) / two_q);
      t -= k * two_q;
    end
    if (t > half_q) begin
      t -= pi_q; flip = 1;
    end else if (t < -half_q) begin
      t += pi_q; flip = 1;
    end
    x = rnd(GAIN30, 30 - FRAC);
    y = 0;
    z = t;
    for (int i = 0; i < STEPS; i++) begin
      dx = sra(y, i); dy = sra(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x <<< GUARD;
    y = y <<< GUARD;
    if (x < 0) begin
      z = (y >= 0) ? rnd(PI30, 30 - FRAC) : -rnd(PI30, 30 - FRAC);
      x = -x; y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = sra(y, i); dy = sra(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint root_nearest(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    if (v > r) r++;
    return longint'(r);
  endfunction

  function automatic longint cos_ratio(longint num, longint unsigned den);
    longint unsigned r, q;
    r = (num < 0) ? longint'(-num) : num;
    q = 0;
    if (r >= den) begin
      q = 1; r -= den;
    end
    for (int i = 0; i < FRAC; i++) begin
      r <<= 1; q <<= 1;
      if (r >= den) begin
        r -= den; q |= 1;
      end
    end
    r <<= 1;
    if (r >= den) q++;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic joint_beat_t solve_pose(pose_beat_t p);
    joint_beat_t j;
    longint th, c, s, wx, wy, num, d, s2, k1, k2, q1, q2, q3, one, mag;
    longint unsigned den;
    j = '0;
    th = p.th;
    one = longint'(1) << FRAC;
    rotate(th, c, s);
    wx = longint'(p.tx) - qmul(link3, c);
    wy = longint'(p.ty) - qmul(link3, s);
    if (link1 == 0 || link2 == 0) return j;
    num = wx * wx + wy * wy - link1 * link1 - link2 * link2;
    den = 2 * link1 * link2;
    mag = (num < 0) ? -num : num;
    if (longint'(mag) > longint'(den)) return j;
    d = cos_ratio(num, den);
    s2 = root_nearest(one * one - d * d);
    q2 = vec_angle(s2, d);
    k1 = link1 + qmul(link2, d);
    k2 = qmul(link2, s2);
    q1 = vec_angle(wy, wx) - vec_angle(k2, k1);
    q3 = th - q1 - q2;
    j.solvable = 1'b1;
    j.base = q1[ANG_W-1:0];
    j.elbow = q2[ANG_W-1:0];
    j.wrist = q3[ANG_W-1:0];
    return j;
  endfunction

  // ---------------- checking ----------------
  task automatic report(input string what, input longint got, input longint want);
    fail_count++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // driver: pose beats leave from the queue, bursty gaps
  initial begin
    pose_ch.valid = 1'b0;
    pose_ch.target_x = '0;
    pose_ch.target_y = '0;
    pose_ch.target_angle = '0;
    joint_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    pose_taken = !rst && pose_ch.valid && pose_ch.ready;
    if (pose_taken) begin
      joint_expect.push_back(solve_pose(pose_queue.pop_front()));
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pose_ch.valid <= 1'b0;
    end else if (pose_ch.valid && !pose_taken) begin
      // beat still waiting for ready: hold it
    end else begin
      if (src_gap > 0) src_gap--;
      else if (!quiet_phase && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 7);
      if (src_gap == 0 && pose_queue.size() > 0) begin
        pose_ch.valid <= 1'b1;
        pose_ch.target_x <= pose_queue[0].tx;
        pose_ch.target_y <= pose_queue[0].ty;
        pose_ch.target_angle <= pose_queue[0].th;
      end else begin
        pose_ch.valid <= 1'b0;
      end
    end
  end

  // monitor side: bursty back-pressure, compare at rising edge
  always @(negedge clk) begin
    if (rst) begin
      joint_ch.ready <= 1'b0;
    end else begin
      if (snk_gap > 0) snk_gap--;
      else if (!quiet_phase && $urandom_range(0, 9) == 0) snk_gap = $urandom_range(1, 7);
      joint_ch.ready <= (snk_gap == 0);
    end
  end

  always @(posedge clk) begin
    joint_beat_t want;
    if (!rst && joint_ch.valid && joint_ch.ready) begin
      if (joint_expect.size() == 0) begin
        report("unexpected beat", joint_ch.solvable, 0);
      end else begin
        want = joint_expect.pop_front();
        if (joint_ch.solvable !== want.solvable)
          report("solvable", joint_ch.solvable, want.solvable);
        if (joint_ch.base_angle !== want.base)
          report("base_angle", joint_ch.base_angle, want.base);
        if (joint_ch.elbow_angle !== want.elbow)
          report("elbow_angle", joint_ch.elbow_angle, want.elbow);
        if (joint_ch.wrist_angle !== want.wrist)
          report("wrist_angle", joint_ch.wrist_angle, want.wrist);
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_LINK1) link1 = data[LEN_W-1:0];
    else if (addr == ADDR_LINK2) link2 = data[LEN_W-1:0];
    else if (addr == ADDR_LINK3) link3 = data[LEN_W-1:0];
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_links(input longint a, input longint b, input longint c);
    apb_write(ADDR_LINK1, 32'(a));
    apb_write(ADDR_LINK2, 32'(b));
    apb_write(ADDR_LINK3, 32'(c));
  endtask

  task automatic push_pose(input longint x, input longint y, input longint t);
    pose_beat_t p;
    p.tx = x[POS_W-1:0];
    p.ty = y[POS_W-1:0];
    p.th = t[TH_W-1:0];
    pose_queue.push_back(p);
  endtask

  // drain: all poses taken, all answers back, then the pipe tail
  task automatic drain();
    while (pose_queue.size() > 0 || joint_expect.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  // mostly reachable targets: pick a radius inside the annulus, random heading
  task automatic push_reachable();
    real r, a, th, ra, rb;
    ra = (link1 > link2 ? link1 - link2 : link2 - link1);
    rb = link1 + link2;
    r = ra + (rb - ra) * ($urandom_range(0, 1000) / 1000.0);
    a = ($urandom_range(0, 62831) / 10000.0) - 3.14159;
    th = $signed($urandom_range(0, 411774)) - 205887;
    push_pose(longint'(r * $cos(a) + link3 * $cos(th / 65536.0)),
              longint'(r * $sin(a) + link3 * $sin(th / 65536.0)), longint'(th));
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: push_pose($signed(24'($urandom)), $signed(24'($urandom)),
                     $signed(19'($urandom)));
        1: push_pose($urandom_range(0, 400000) - 200000,
                     $urandom_range(0, 400000) - 200000,
                     $urandom_range(0, 411774) - 205887);
        default: push_reachable();
      endcase
    end
    drain();
  endtask

  initial begin
    link1 = LINK1_RST; link2 = LINK2_RST; link3 = LINK3_RST;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: field extremes, reachable edges, zero vector, wrapped angle
    push_pose(0, 0, 0);
    push_pose(8388607, 8388607, 205887);
    push_pose(-8388608, -8388608, -205887);
    push_pose(8388607, -8388608, 262143);
    push_pose(-8388608, 8388607, -262144);
    push_pose(link1 + link2 + link3, 0, 0);             // fully stretched
    push_pose(link1 - link2 + link3, 0, 0);             // fully folded
    push_pose(link1 + link2 + link3 + 1, 0, 0);         // just beyond reach
    push_pose(link3, 0, 0);                             // wrist at origin
    push_pose(-30000, 10000, 205887);
    push_pose(-30000, -10000, -205887);
    push_pose(20000, 30000, 102944);
    push_pose(0, 40000, -102944);
    push_pose(-1, -1, -1);
    drain();

    // equal links and zero end link reach the origin exactly
    set_links(30000, 30000, 0);
    push_pose(0, 0, 0);
    push_pose(60000, 0, 0);
    push_pose(-60000, 0, 100000);
    random_phase(60);

    set_links(0, 21627, 15729);        // zero first link
    push_pose(20000, 0, 0);
    random_phase(10);
    set_links(28180, 0, 15729);        // zero second link
    random_phase(10);

    set_links(1048575, 1048575, 1048575);
    random_phase(60);
    set_links(1, 1, 1);
    push_pose(2, 0, 0);
    push_pose(1, 1, 0);
    random_phase(30);
    set_links(100, 1048575, 500);
    random_phase(60);
    set_links(28180, 21627, 15729);
    random_phase(130);

    quiet_phase = 1;
    random_phase(60);

    if (fail_count == 0) begin
      $display("planar_three_link_inverse_kinematics verification clean");
    end else begin
      $display("planar_three_link_inverse_kinematics verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("planar_three_link_inverse_kinematics verification failed");
    $finish;
  end
endmodule
